[rtl/assert_macros.svh]
// Assertion macros shared by the timer bank RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CHK_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define CHK_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mtb_pkg.sv]
// Types and codes of the multi-timer bank.
`timescale 1ns / 1ps
`default_nettype none
package mtb_pkg;

	localparam int ID_W     = 4;   // timer id width
	localparam int CNT_W    = 5;   // timers-in-use count, up to 16
	localparam int MAX_CAP  = 16;  // ids are 4 bits wide
	localparam int PERIOD_W = 32;
	localparam int REM_W    = 32;

	localparam logic [REM_W-1:0] REM_MAX = 32'h7fff_ffff;
	localparam logic [REM_W-1:0] REM_MIN = 32'h8000_0000;

	// Input item modes
	typedef enum logic [2:0] {
		MODE_TICK    = 3'd0,
		MODE_ADD     = 3'd1,
		MODE_SET     = 3'd2,
		MODE_START   = 3'd3,
		MODE_STOP    = 3'd4,
		MODE_QUERY   = 3'd5
	} mode_t;

	// Result kinds
	typedef enum logic [1:0] {
		EV_DONE    = 2'd0,
		EV_EXPIRED = 2'd1,
		EV_FULL    = 2'd2,
		EV_BADID   = 2'd3
	} event_kind_t;

	// Classified commands passed from front to back
	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_ADD,
		CMD_FULL,
		CMD_BADID,
		CMD_SET,
		CMD_START,
		CMD_STOP,
		CMD_QUERY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [ID_W-1:0]       id;          // target id, or new id for add
		logic [PERIOD_W-1:0]   period;
		logic                  single_shot;
		logic [CNT_W-1:0]      count;       // timers to walk on a tick
	} cmd_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		B_IDLE,
		B_WALK,
		B_FINISH
	} bstate_t;

endpackage
`default_nettype wire

[rtl/mtb_ifs.sv]
// Command and event channel interfaces of the multi-timer bank.
`timescale 1ns / 1ps
`default_nettype none
interface mtb_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [3:0]  timer_id;
	logic [31:0] period;
	logic        single_shot;

	modport source (output valid, output mode, output timer_id, output period,
		output single_shot, input ready);
	modport sink (input valid, input mode, input timer_id, input period,
		input single_shot, output ready);
endinterface

interface mtb_evt_if;
	logic               valid;
	logic               ready;
	logic [1:0]         event_kind;
	logic [3:0]         which_timer;
	logic               running;
	logic signed [31:0] remaining;
	logic               last_result;

	modport source (output valid, output event_kind, output which_timer,
		output running, output remaining, output last_result, input ready);
	modport sink (input valid, input event_kind, input which_timer,
		input running, input remaining, input last_result, output ready);
endinterface
`default_nettype wire

[rtl/mtb_front.sv]
// Front end: accepts command items, checks ids and capacity, assigns new ids.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mtb_front
	import mtb_pkg::*;
#(
	parameter int NUM_TIMERS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	mtb_cmd_if.sink      cmd,
	output logic         q_push,
	output cmd_t         q_wdata,
	input  wire          q_full
);

	localparam int CAP = (NUM_TIMERS < MAX_CAP) ? NUM_TIMERS : MAX_CAP;
	localparam int CW  = $clog2(CAP + 1);

	logic [CW-1:0] cnt_q;
	logic          accept;
	logic          full;
	logic          bad_id;
	logic          add_ok;

	assign cmd.ready = !q_full;
	assign accept    = cmd.valid && !q_full;
	assign full      = (cnt_q == CW'(CAP));
	assign bad_id    = (CNT_W'(cmd.timer_id) >= CNT_W'(cnt_q));

	// Classify the item; unused modes are dropped here
	always_comb begin
		q_push              = 1'b0;
		add_ok              = 1'b0;
		q_wdata.kind        = CMD_TICK;
		q_wdata.id          = cmd.timer_id;
		q_wdata.period      = cmd.period;
		q_wdata.single_shot = cmd.single_shot;
		q_wdata.count       = CNT_W'(cnt_q);
		unique case (cmd.mode)
			MODE_TICK: begin
				q_push = accept;
			end
			MODE_ADD: begin
				q_push = accept;
				if (full) begin
					q_wdata.kind = CMD_FULL;
				end else begin
					add_ok       = 1'b1;
					q_wdata.kind = CMD_ADD;
					q_wdata.id   = ID_W'(cnt_q);
				end
			end
			MODE_SET, MODE_START, MODE_STOP, MODE_QUERY: begin
				q_push = accept;
				if (bad_id) begin
					q_wdata.kind = CMD_BADID;
				end else begin
					unique case (cmd.mode)
						MODE_SET:   q_wdata.kind = CMD_SET;
						MODE_START: q_wdata.kind = CMD_START;
						MODE_STOP:  q_wdata.kind = CMD_STOP;
						default:    q_wdata.kind = CMD_QUERY;
					endcase
				end
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	// Timers in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (q_push && add_ok) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	`CHK_NEXT(a_add_bumps_count, clk, arst_n, q_push && add_ok, cnt_q == $past(cnt_q) + CW'(1), "add did not advance the timer count")
	`CHK_IMPL(a_count_in_range, clk, arst_n, 1'b1, cnt_q <= CW'(CAP), "timer count above capacity")

endmodule
`default_nettype wire

[rtl/mtb_fifo.sv]
// Two-entry command queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mtb_fifo
	import mtb_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   push,
	input  cmd_t  wdata,
	output logic  full,
	input  wire   pop,
	output logic  valid,
	output cmd_t  rdata
);

	cmd_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign rdata = mem_q[rptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop)  rptr_q <= !rptr_q;
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	`CHK_IMPL(a_no_overflow, clk, arst_n, push, !full || pop, "push into a full queue")
	`CHK_IMPL(a_empty_ptrs, clk, arst_n, cnt_q == 2'd0, wptr_q == rptr_q, "empty queue with unequal pointers")

endmodule
`default_nettype wire

[rtl/mtb_back.sv]
// Back end: time base, timer tables, tick walk and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mtb_back
	import mtb_pkg::*;
#(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_WIDTH = 32
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          q_valid,
	input  cmd_t         q_rdata,
	output logic         q_pop,
	mtb_evt_if.source    evt
);

	localparam int CAP = (NUM_TIMERS < MAX_CAP) ? NUM_TIMERS : MAX_CAP;
	localparam int IW  = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int TW  = TIME_WIDTH;
	localparam int XW  = TW + REM_W;
	localparam logic signed [XW-1:0] XMAX = {{(TW + 1){1'b0}}, {(REM_W - 1){1'b1}}};
	localparam logic signed [XW-1:0] XMIN = {{(TW + 1){1'b1}}, {(REM_W - 1){1'b0}}};

	// Time base and tables
	logic [TW-1:0]  now_q;
	logic [TW-1:0]  deadline_q [CAP];
	logic [TW-1:0]  reload_q   [CAP];
	logic           shot_q     [CAP];
	logic           en_q       [CAP];

	// Sequencer
	bstate_t          state_q, state_n;
	logic [IW-1:0]    idx_q;
	logic [CNT_W-1:0] tcnt_q;
	logic             held_q;
	logic [ID_W-1:0]  held_id_q;
	logic             held_run_q;

	// Result register
	logic               ov_q;
	event_kind_t        o_kind_q;
	logic [ID_W-1:0]    o_id_q;
	logic               o_run_q;
	logic [REM_W-1:0]   o_rem_q;
	logic               o_last_q;

	// Table access
	logic [IW-1:0]  rd_idx;
	logic [TW-1:0]  rd_deadline;
	logic [TW-1:0]  rd_reload;
	logic           rd_shot;
	logic           rd_en;
	logic [TW-1:0]  period_t;
	logic [TW-1:0]  sum_period;
	logic [TW-1:0]  sum_reload;
	logic [TW-1:0]  since_dl;
	logic [TW-1:0]  diff;
	logic signed [XW-1:0] diff_x;
	logic [REM_W-1:0] rem_sat;
	logic           expired;
	logic           out_free;
	logic           at_end;

	// Control decoded each cycle
	logic             wr_dl, wr_rl, wr_shot, wr_en, en_val;
	logic [TW-1:0]    dl_val;
	logic             now_inc, idx_clr, idx_adv, tcnt_ld;
	logic             held_set, held_clr;
	logic             ld_out;
	event_kind_t      n_kind;
	logic [ID_W-1:0]  n_id;
	logic             n_run;
	logic [REM_W-1:0] n_rem;
	logic             n_last;

	assign rd_idx      = (state_q == B_IDLE) ? q_rdata.id[IW-1:0] : idx_q;
	assign rd_deadline = deadline_q[rd_idx];
	assign rd_reload   = reload_q[rd_idx];
	assign rd_shot     = shot_q[rd_idx];
	assign rd_en       = en_q[rd_idx];
	assign period_t    = TW'(q_rdata.period);
	assign sum_period  = now_q + period_t;
	assign sum_reload  = now_q + rd_reload;
	assign since_dl    = now_q - rd_deadline;
	assign expired     = rd_en && !since_dl[TW-1];
	assign out_free    = !ov_q || evt.ready;
	assign at_end      = ((CNT_W'(idx_q) + CNT_W'(1)) == tcnt_q);

	// Remaining ticks, sign-extended and clamped to 32 bits
	assign diff   = rd_deadline - now_q;
	assign diff_x = XW'(signed'(diff));
	always_comb begin
		if (diff_x > XMAX) begin
			rem_sat = REM_MAX;
		end else if (diff_x < XMIN) begin
			rem_sat = REM_MIN;
		end else begin
			rem_sat = diff_x[REM_W-1:0];
		end
	end

	// Sequencer next state and table writes
	always_comb begin
		state_n  = state_q;
		q_pop    = 1'b0;
		wr_dl    = 1'b0;
		wr_rl    = 1'b0;
		wr_shot  = 1'b0;
		wr_en    = 1'b0;
		en_val   = 1'b0;
		dl_val   = sum_reload;
		now_inc  = 1'b0;
		idx_clr  = 1'b0;
		idx_adv  = 1'b0;
		tcnt_ld  = 1'b0;
		held_set = 1'b0;
		held_clr = 1'b0;
		ld_out   = 1'b0;
		n_kind   = EV_DONE;
		n_id     = q_rdata.id;
		n_run    = 1'b0;
		n_rem    = '0;
		n_last   = 1'b1;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					if (q_rdata.kind == CMD_TICK) begin
						q_pop   = 1'b1;
						now_inc = 1'b1;
						idx_clr = 1'b1;
						tcnt_ld = 1'b1;
						if (q_rdata.count != '0) state_n = B_WALK;
					end else if (out_free) begin
						q_pop  = 1'b1;
						ld_out = 1'b1;
						unique case (q_rdata.kind)
							CMD_ADD: begin
								wr_dl   = 1'b1;
								dl_val  = sum_period;
								wr_rl   = 1'b1;
								wr_shot = 1'b1;
								wr_en   = 1'b1;
								en_val  = 1'b0;
							end
							CMD_FULL: begin
								n_kind = EV_FULL;
								n_id   = '0;
							end
							CMD_BADID: begin
								n_kind = EV_BADID;
							end
							CMD_SET: begin
								wr_dl  = 1'b1;
								dl_val = sum_period;
								wr_rl  = 1'b1;
								n_run  = rd_en;
							end
							CMD_START: begin
								wr_en  = 1'b1;
								en_val = 1'b1;
								wr_dl  = 1'b1;
								n_run  = 1'b1;
							end
							CMD_STOP: begin
								wr_en  = 1'b1;
								en_val = 1'b0;
							end
							CMD_QUERY: begin
								n_run = rd_en;
								n_rem = rem_sat;
							end
							CMD_TICK: begin
								ld_out = 1'b0;
							end
						endcase
					end
				end
			end
			B_WALK: begin
				// An expiry may have to push the held one out first
				if (!(expired && held_q && !out_free)) begin
					if (expired) begin
						wr_dl = 1'b1;
						if (rd_shot) begin
							wr_en  = 1'b1;
							en_val = 1'b0;
						end
						if (held_q) begin
							ld_out = 1'b1;
							n_kind = EV_EXPIRED;
							n_id   = held_id_q;
							n_run  = held_run_q;
							n_last = 1'b0;
						end
						held_set = 1'b1;
					end
					if (at_end) begin
						state_n = B_FINISH;
					end else begin
						idx_adv = 1'b1;
					end
				end
			end
			B_FINISH: begin
				// The last expiry found closes the tick's results
				if (!held_q) begin
					state_n = B_IDLE;
				end else if (out_free) begin
					ld_out   = 1'b1;
					n_kind   = EV_EXPIRED;
					n_id     = held_id_q;
					n_run    = held_run_q;
					n_last   = 1'b1;
					held_clr = 1'b1;
					state_n  = B_IDLE;
				end
			end
			default: begin
				state_n = B_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			now_q   <= '0;
			idx_q   <= '0;
			tcnt_q  <= '0;
			held_q  <= 1'b0;
			ov_q    <= 1'b0;
			for (int i = 0; i < CAP; i++) en_q[i] <= 1'b0;
		end else begin
			state_q <= state_n;
			if (now_inc) now_q <= now_q + TW'(1);
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_adv) begin
				idx_q <= idx_q + IW'(1);
			end
			if (tcnt_ld) tcnt_q <= q_rdata.count;
			if (held_set) begin
				held_q <= 1'b1;
			end else if (held_clr) begin
				held_q <= 1'b0;
			end
			if (ld_out) begin
				ov_q <= 1'b1;
			end else if (evt.ready) begin
				ov_q <= 1'b0;
			end
			if (wr_en) en_q[rd_idx] <= en_val;
		end
	end

	// Timer tables, held expiry and result payload
	always_ff @(posedge clk) begin
		if (wr_dl)   deadline_q[rd_idx] <= dl_val;
		if (wr_rl)   reload_q[rd_idx]   <= period_t;
		if (wr_shot) shot_q[rd_idx]     <= q_rdata.single_shot;
		if (held_set) begin
			held_id_q  <= ID_W'(idx_q);
			held_run_q <= !rd_shot;
		end
		if (ld_out) begin
			o_kind_q <= n_kind;
			o_id_q   <= n_id;
			o_run_q  <= n_run;
			o_rem_q  <= n_rem;
			o_last_q <= n_last;
		end
	end

	assign evt.valid       = ov_q;
	assign evt.event_kind  = o_kind_q;
	assign evt.which_timer = o_id_q;
	assign evt.running     = o_run_q;
	assign evt.remaining   = signed'(o_rem_q);
	assign evt.last_result = o_last_q;

	`CHK_IMPL(a_idle_nothing_held, clk, arst_n, state_q == B_IDLE, !held_q, "expiry still held in idle")
	`CHK_IMPL(a_walk_in_range, clk, arst_n, state_q == B_WALK, CNT_W'(idx_q) < tcnt_q, "walk index past timer count")

endmodule
`default_nettype wire

[rtl/multi_timer_bank_unit.sv]
// Top level of the multi-timer bank: front end, command queue and back end.
`timescale 1ns / 1ps
`default_nettype none
// A bank of up to min(NUM_TIMERS, 16) software-style timers on one time base.
// Add, set_timeout, start, stop and query are handled in the back end once
// the result register is free, and each gives one result. A tick with no
// timer assigned only advances the time base; otherwise the back end walks
// the assigned timers one per cycle through a single table port, pausing
// while an expiry waits on an unread result, gives one expired result per
// expiring timer in id order (or none), and marks the last one with
// last_result. The front end classifies items into a two-entry queue and
// accepts while it has room, even as the back end walks or a result waits.
// Modes 6 and 7 are accepted and dropped. Only assigned timers are read.
module multi_timer_bank_unit
	import mtb_pkg::*;
#(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_WIDTH = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	mtb_cmd_if.sink    cmd,
	mtb_evt_if.source  evt
);

	logic q_push;
	cmd_t q_wdata;
	logic q_full;
	logic q_pop;
	logic q_valid;
	cmd_t q_rdata;

	mtb_front #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_push  (q_push),
		.q_wdata (q_wdata),
		.q_full  (q_full)
	);

	mtb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	mtb_back #(
		.NUM_TIMERS (NUM_TIMERS),
		.TIME_WIDTH (TIME_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.evt     (evt)
	);

endmodule
`default_nettype wire
